### src/imufd_pkg.sv
// ----------------------------------------------------------------------------
// imufd_pkg
// Shared types and constants for the 11-byte sensor frame deframer/decoder.
// ----------------------------------------------------------------------------
package imufd_pkg;

	// frame layout and protocol bytes
	localparam int unsigned FRAME_LEN = 11;
	localparam logic [7:0]  HDR_BYTE   = 8'h55;
	localparam logic [7:0]  TYPE_MASK  = 8'h50;
	localparam logic [7:0]  TYPE_ACCEL = 8'h51;
	localparam logic [7:0]  TYPE_ANGLE = 8'h53;
	localparam logic [7:0]  TYPE_PRESS = 8'h56;

	// frame kind codes on the result
	localparam logic [1:0] KIND_ACCEL = 2'd0;
	localparam logic [1:0] KIND_ANGLE = 2'd1;
	localparam logic [1:0] KIND_PRESS = 2'd2;

	// enable mask bits
	localparam int unsigned EN_TEMP  = 0;
	localparam int unsigned EN_ROLL  = 1;
	localparam int unsigned EN_PITCH = 2;
	localparam int unsigned EN_YAW   = 3;
	localparam int unsigned EN_PRESS = 4;

	// widths
	localparam int unsigned MASK_W  = 5;
	localparam int unsigned FILL_W  = 4;
	localparam int unsigned ANGLE_W = 17;
	localparam int unsigned TDATA_W = 104;

	// a candidate frame and its check result, as seen by the decoder
	typedef struct packed {
		logic                           ok;
		logic [FRAME_LEN-1:0][7:0]      bytes;
	} frame_t;

	// one decoded result
	typedef struct packed {
		logic [1:0]                  frame_kind;
		logic signed [15:0]          temperature_centi;
		logic                        temperature_valid;
		logic signed [ANGLE_W-1:0]   roll_deg_q8;
		logic                        roll_valid;
		logic signed [ANGLE_W-1:0]   pitch_deg_q8;
		logic                        pitch_valid;
		logic signed [ANGLE_W-1:0]   yaw_deg_q8;
		logic                        yaw_valid;
		logic [31:0]                 pressure_raw;
		logic                        pressure_valid;
	} result_t;

	// raw angle word to degrees with 8 fraction bits: (raw*45) >>> 5
	function automatic logic signed [ANGLE_W-1:0] angle_q8(input logic [15:0] raw);
		logic signed [21:0] prod;
		prod = 22'(signed'(raw)) * 22'sd45;
		return ANGLE_W'(prod >>> 5);
	endfunction

endpackage

### src/imufd_window.sv
// ----------------------------------------------------------------------------
// imufd_window
// Eleven-byte receive window with fill count, header/type/checksum checks and
// the resynchronising byte drops.
// ----------------------------------------------------------------------------
module imufd_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output imufd_pkg::frame_t   frame
);

	localparam int unsigned LEN = imufd_pkg::FRAME_LEN;

	logic [imufd_pkg::FILL_W-1:0] fill_q;
	logic [LEN-2:0][7:0]          win_q;

	logic       full;
	logic       hdr_ok;
	logic       type_ok;
	logic       sum_ok;
	logic [7:0] sum;

	// checks on the window completed by the incoming byte
	always_comb begin
		sum = '0;
		for (int i = 0; i < LEN - 1; i++) begin
			sum = sum + win_q[i];
		end
		full    = (fill_q == imufd_pkg::FILL_W'(LEN - 1));
		hdr_ok  = (win_q[0] == imufd_pkg::HDR_BYTE);
		type_ok = ((win_q[1] & imufd_pkg::TYPE_MASK) != 8'h00);
		sum_ok  = (sum == rx_byte);
		frame.ok    = full && hdr_ok && type_ok && sum_ok;
		frame.bytes = {rx_byte, win_q};
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step) begin
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end else if (!hdr_ok) begin
				fill_q <= imufd_pkg::FILL_W'(LEN - 1);
			end else if (!type_ok) begin
				fill_q <= imufd_pkg::FILL_W'(LEN - 2);
			end else if (!sum_ok) begin
				fill_q <= imufd_pkg::FILL_W'(LEN - 1);
			end else begin
				fill_q <= '0;
			end
		end
	end

	// window bytes: append, or slide by one or two on a bad frame
	always_ff @(posedge clk) begin
		if (step) begin
			if (!full) begin
				win_q[fill_q] <= rx_byte;
			end else if (!hdr_ok || (type_ok && !sum_ok)) begin
				win_q[LEN-3:0] <= win_q[LEN-2:1];
				win_q[LEN-2]   <= rx_byte;
			end else if (!type_ok) begin
				win_q[LEN-4:0] <= win_q[LEN-2:2];
				win_q[LEN-3]   <= rx_byte;
			end
		end
	end

	// fill never goes beyond a full window between words
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= imufd_pkg::FILL_W'(LEN - 1))
		else $error("window fill out of range");

	// a good frame empties the window
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && frame.ok) |=> (fill_q == '0))
		else $error("window not emptied after good frame");

	// a word into a part-filled window grows it by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && !full) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("window fill did not advance");

endmodule

### src/imufd_decode.sv
// ----------------------------------------------------------------------------
// imufd_decode
// Turns a checked frame into a result under the enable mask.
// ----------------------------------------------------------------------------
module imufd_decode (
	input  imufd_pkg::frame_t                 frame,
	input  logic [imufd_pkg::MASK_W-1:0]      mask,
	output imufd_pkg::result_t                res,
	output logic                              res_valid
);

	logic [7:0] kind;
	logic       is_accel;
	logic       is_angle;
	logic       is_press;

	// frame type against the enabled fields
	always_comb begin
		kind     = frame.bytes[1];
		is_accel = (kind == imufd_pkg::TYPE_ACCEL) && mask[imufd_pkg::EN_TEMP];
		is_angle = (kind == imufd_pkg::TYPE_ANGLE) &&
		           (mask[imufd_pkg::EN_ROLL] || mask[imufd_pkg::EN_PITCH] ||
		            mask[imufd_pkg::EN_YAW]);
		is_press = (kind == imufd_pkg::TYPE_PRESS) && mask[imufd_pkg::EN_PRESS];
		res_valid = frame.ok && (is_accel || is_angle || is_press);
	end

	// field values, zero where not reported
	always_comb begin
		res = '0;
		if (is_accel) begin
			res.frame_kind        = imufd_pkg::KIND_ACCEL;
			res.temperature_centi = {frame.bytes[9], frame.bytes[8]};
			res.temperature_valid = 1'b1;
		end else if (is_angle) begin
			res.frame_kind = imufd_pkg::KIND_ANGLE;
			if (mask[imufd_pkg::EN_ROLL]) begin
				res.roll_deg_q8 = imufd_pkg::angle_q8({frame.bytes[3], frame.bytes[2]});
				res.roll_valid  = 1'b1;
			end
			if (mask[imufd_pkg::EN_PITCH]) begin
				res.pitch_deg_q8 = imufd_pkg::angle_q8({frame.bytes[5], frame.bytes[4]});
				res.pitch_valid  = 1'b1;
			end
			if (mask[imufd_pkg::EN_YAW]) begin
				res.yaw_deg_q8 = imufd_pkg::angle_q8({frame.bytes[7], frame.bytes[6]});
				res.yaw_valid  = 1'b1;
			end
		end else if (is_press) begin
			res.frame_kind     = imufd_pkg::KIND_PRESS;
			res.pressure_raw   = {frame.bytes[5], frame.bytes[4],
			                      frame.bytes[3], frame.bytes[2]};
			res.pressure_valid = 1'b1;
		end
	end

endmodule

### src/imu_frame_deframer_decoder.sv
// ----------------------------------------------------------------------------
// imu_frame_deframer_decoder
// Deframes 11-byte sum-checked sensor frames from a received byte stream and
// decodes temperature, angle and pressure results.
//
//   channel  dir  payload
//   s_*      in   tdata[7:0] rx_byte
//   m_*      out  tuser[1:0] frame_kind; tdata[103:0] decoded fields
//   cfg_*    in   cfg_wr_data[4:0] sensor_enable_mask
//
// One word is accepted per cycle while m_* is not stalled. A word is held in
// the input register, where the window update and frame decode run, and its
// result is registered onto m_*. Reset empties the window and sets all
// enables. A stalled output holds its word; the input register can still
// take one more input word before s_tready drops.
// ----------------------------------------------------------------------------
module imu_frame_deframer_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] temperature_centi, [16] temperature_valid, [33:17] roll_deg_q8,
	// [34] roll_valid, [51:35] pitch_deg_q8, [52] pitch_valid,
	// [69:53] yaw_deg_q8, [70] yaw_valid, [102:71] pressure_raw,
	// [103] pressure_valid
	output logic [imufd_pkg::TDATA_W-1:0]       m_tdata,
	output logic [1:0]                          m_tuser,   // [1:0] frame_kind
	input  logic                                cfg_wr_en,
	input  logic [imufd_pkg::MASK_W-1:0]        cfg_wr_data
);

	logic [imufd_pkg::MASK_W-1:0] mask_q;
	logic                         vld_s1;
	logic [7:0]                   byte_s1;
	logic                         out_vld_q;
	imufd_pkg::result_t           out_q;

	logic                         adv;
	logic                         step;
	imufd_pkg::frame_t            frame;
	imufd_pkg::result_t           res;
	logic                         res_valid;

	// enable mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
		end else if (cfg_wr_en) begin
			mask_q <= cfg_wr_data;
		end
	end

	// pipeline control
	assign adv      = !out_vld_q || m_tready;
	assign step     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	imufd_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	imufd_decode u_decode (
		.frame     (frame),
		.mask      (mask_q),
		.res       (res),
		.res_valid (res_valid)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	// output packing
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.frame_kind;
	assign m_tdata  = {out_q.pressure_valid, out_q.pressure_raw,
	                   out_q.yaw_valid, out_q.yaw_deg_q8,
	                   out_q.pitch_valid, out_q.pitch_deg_q8,
	                   out_q.roll_valid, out_q.roll_deg_q8,
	                   out_q.temperature_valid, out_q.temperature_centi};

	// every delivered word reports at least one field
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.temperature_valid || out_q.roll_valid ||
		              out_q.pitch_valid || out_q.yaw_valid || out_q.pressure_valid))
		else $error("result word with no field reported");

	// a held input word never moves while the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && out_vld_q && !m_tready) |=> (vld_s1 && $stable(byte_s1)))
		else $error("input register lost a word under stall");

	// a stalled result word is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |=> (out_vld_q && $stable(out_q)))
		else $error("result word overwritten under stall");

endmodule
